// ----- rtl/roulette_wheel_selector_assert.svh -----
// Assertion macros shared by the roulette wheel selector RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef ROULETTE_WHEEL_SELECTOR_ASSERT_SVH
`define ROULETTE_WHEEL_SELECTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define RWS_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define RWS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rws_pkg.sv -----
// Package for the roulette wheel selector: field widths, codes and FSM state type.
// No dependencies.
package rws_pkg;

    localparam int IDX_W    = 7;
    localparam int FIT_W    = 32;
    localparam int RAND_IN_W = 16;

    // Transaction kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SELECT = 1'b1;

    // One fitness unit in 16.16 fixed point
    localparam logic [FIT_W-1:0] ONE_UNIT = 32'h0001_0000;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_SUM_TAIL,
        ST_CHECK,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_RESULT
    } state_t;

endpackage

// ----- rtl/rws_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/roulette_wheel_selector.sv -----
// Roulette wheel selector top level: fitness table in RAM, sum and scan sequencer.
// Depends on rws_pkg, rws_ram and roulette_wheel_selector_assert.svh.
//
// Usage:
// Input channel (in_valid/in_stall) carries one transaction: kind, member_index,
// fitness_value, random_fraction. A write stores fitness_value at member_index
// (indices at or above POP_SIZE are dropped) and returns the index with error 0.
// A select sums the whole table, then walks it with a running sum and returns the
// first index whose cumulative fitness times 2^RAND_BITS exceeds r times total.
// A total below one fitness unit returns index 0 with error 1.
// Output channel (out_valid/out_stall) returns exactly one result per transaction.
// The single RAM read port sets the pace of a select: one entry per cycle
// while totaling, one per cycle while scanning.
// One transaction is in flight at a time; in_stall is high while it runs.
// A result sits in the output register while out_stall is high, and the block
// takes the next transaction meanwhile; its own result waits for that slot.
// After reset the block clears the table, one entry per cycle, with in_stall high.
module roulette_wheel_selector #(
    parameter int POP_SIZE  = 128,
    parameter int RAND_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic [rws_pkg::IDX_W-1:0]       member_index,
    input  logic [rws_pkg::FIT_W-1:0]       fitness_value,
    input  logic [rws_pkg::RAND_IN_W-1:0]   random_fraction,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rws_pkg::IDX_W-1:0]       selected_index,
    output logic                            error
);

    import rws_pkg::*;

    `include "roulette_wheel_selector_assert.svh"

    localparam int AW = $clog2(POP_SIZE);
    localparam int TW = FIT_W + AW;
    localparam int RB = (RAND_BITS < RAND_IN_W) ? RAND_BITS : RAND_IN_W;
    localparam int PW = RB + TW;
    localparam int CW = TW + RAND_BITS;
    localparam int XW = (AW > IDX_W) ? AW + 1 : IDX_W + 1;

    state_t            state_reg, state_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic [TW-1:0]     total_reg, total_next;
    logic [TW-1:0]     cum_reg, cum_next;
    logic [PW-1:0]     rt_reg, rt_next;
    logic [RB-1:0]     r_reg, r_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic              res_err_reg, res_err_next;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic              out_err_reg, out_err_next;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [FIT_W-1:0]  ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [FIT_W-1:0]  ram_rd_data;

    logic [XW-1:0]     idx_x;
    logic              in_range;
    logic              cnt_last;
    logic [TW-1:0]     acc_sum;
    logic [TW-1:0]     cum_sum;
    logic              hit;
    logic              slot_free;

    // Fitness table
    rws_ram #(
        .WIDTH (FIT_W),
        .DEPTH (POP_SIZE)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Datapath helpers
    assign idx_x     = XW'(member_index);
    assign in_range  = idx_x < XW'(POP_SIZE);
    assign cnt_last  = cnt_reg == AW'(POP_SIZE - 1);
    assign acc_sum   = total_reg + TW'(ram_rd_data);
    assign cum_sum   = cum_reg + TW'(ram_rd_data);
    assign hit       = CW'(rt_reg) < {cum_sum, {RAND_BITS{1'b0}}};
    assign slot_free = !out_valid_reg || !out_stall;

    // Sequencer: next state, RAM control and result capture
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        cum_next       = cum_reg;
        rt_next        = rt_reg;
        r_next         = r_reg;
        rd_pend_next   = 1'b0;
        rd_idx_next    = rd_idx_reg;
        res_idx_next   = res_idx_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_idx_next   = out_idx_reg;
        out_err_next   = out_err_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = cnt_reg;
        ram_wr_data    = '0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = cnt_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en = 1'b1;
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == KIND_WRITE)
                    begin
                        ram_wr_en    = in_range;
                        ram_wr_addr  = AW'(idx_x);
                        ram_wr_data  = fitness_value;
                        res_idx_next = member_index;
                        res_err_next = 1'b0;
                        state_next   = ST_RESULT;
                    end
                    else
                    begin
                        r_next     = RB'(random_fraction);
                        total_next = '0;
                        cnt_next   = '0;
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                ram_rd_en    = 1'b1;
                rd_pend_next = 1'b1;
                rd_idx_next  = cnt_reg;
                if (rd_pend_reg)
                begin
                    total_next = acc_sum;
                end
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_SUM_TAIL;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_SUM_TAIL:
            begin
                total_next = acc_sum;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (total_reg < TW'(ONE_UNIT))
                begin
                    res_idx_next = '0;
                    res_err_next = 1'b1;
                    state_next   = ST_RESULT;
                end
                else
                begin
                    rt_next    = PW'(r_reg) * PW'(total_reg);
                    cum_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ram_rd_en    = 1'b1;
                rd_pend_next = 1'b1;
                rd_idx_next  = cnt_reg;
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_SCAN_TAIL;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
                if (rd_pend_reg)
                begin
                    cum_next = cum_sum;
                    if (hit)
                    begin
                        res_idx_next = IDX_W'(rd_idx_reg);
                        res_err_next = 1'b0;
                        rd_pend_next = 1'b0;
                        cnt_next     = '0;
                        state_next   = ST_RESULT;
                    end
                end
            end
            ST_SCAN_TAIL:
            begin
                // Last entry: picked on a hit and also when nothing qualified
                res_idx_next = IDX_W'(rd_idx_reg);
                res_err_next = 1'b0;
                state_next   = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = res_idx_reg;
                    out_err_next   = res_err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        total_reg   <= total_next;
        cum_reg     <= cum_next;
        rt_reg      <= rt_next;
        r_reg       <= r_next;
        rd_idx_reg  <= rd_idx_next;
        res_idx_reg <= res_idx_next;
        res_err_reg <= res_err_next;
        out_idx_reg <= out_idx_next;
        out_err_reg <= out_err_next;
    end

    // Ports
    assign in_stall       = state_reg != ST_IDLE;
    assign out_valid      = out_valid_reg;
    assign selected_index = out_idx_reg;
    assign error          = out_err_reg;

    // Checks
    `RWS_ASSERT_IMPL(a_load_from_result, $rose(out_valid_reg), $past(state_reg == ST_RESULT), "result loaded outside result state")
    `RWS_ASSERT_IMPL(a_err_index_zero, out_valid_reg && out_err_reg, out_idx_reg == '0, "error result with nonzero index")
    `RWS_ASSERT_IMPL(a_rd_pend_src, rd_pend_reg, $past(state_reg == ST_SUM || state_reg == ST_SCAN), "read data flagged without a read")
    `RWS_ASSERT_IMPL(a_cum_bounded, state_reg == ST_SCAN, cum_reg <= total_reg, "running sum exceeds total")
    `RWS_ASSERT_NEXT(a_select_starts, in_valid && !in_stall && kind == KIND_SELECT, state_reg == ST_SUM, "select did not start totaling")

endmodule

// ----- sim/roulette_wheel_selector_tb.sv -----
// Self-checking testbench for roulette_wheel_selector: directed table, then random writes
// and selects checked against a behavioral roulette wheel kept in the testbench.
// Depends on rws_pkg and the roulette_wheel_selector RTL.
module roulette_wheel_selector_tb;
    import rws_pkg::*;

    localparam int POP_SIZE   = 128;
    localparam int RAND_BITS  = 16;
    localparam int NPROBE     = 25;
    localparam int NRANDOM    = 900;
    localparam int IDLE_PCT   = 12;
    localparam int SETTLE     = 2 * POP_SIZE + 40;
    localparam int HANG_LIMIT = 4000;

    // One expected result
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             err;
    } pick_t;

    // One directed row; the typed expectation is used only when known is set
    typedef struct packed {
        logic                 k;
        logic [IDX_W-1:0]     idx;
        logic [FIT_W-1:0]     fit;
        logic [RAND_IN_W-1:0] r;
        logic                 known;
        logic [IDX_W-1:0]     t_idx;
        logic                 t_err;
    } probe_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 kind = KIND_WRITE;
    logic [IDX_W-1:0]     member_index = '0;
    logic [FIT_W-1:0]     fitness_value = '0;
    logic [RAND_IN_W-1:0] random_fraction = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [IDX_W-1:0]     selected_index;
    logic                 error;

    logic [FIT_W-1:0] wheel [POP_SIZE];
    pick_t            pending_picks [$];
    pick_t            due;
    probe_row_t       probes [NPROBE];
    logic             calm = 1'b0;
    int               fail_count = 0;
    int               quiet_cycles = 0;

    roulette_wheel_selector #(
        .POP_SIZE  (POP_SIZE),
        .RAND_BITS (RAND_BITS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .member_index    (member_index),
        .fitness_value   (fitness_value),
        .random_fraction (random_fraction),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .selected_index  (selected_index),
        .error           (error)
    );

    // Clock, period 12
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Behavioral wheel: updates the table on a write, spins it on a select
    function automatic pick_t spin_wheel(input logic k, input logic [IDX_W-1:0] idx,
                                         input logic [FIT_W-1:0] fit,
                                         input logic [RAND_IN_W-1:0] r);
        pick_t       res;
        logic [47:0] total;
        logic [47:0] running;
        logic [63:0] spin;
        logic [63:0] scaled;
        logic [63:0] r_wide;
        logic [63:0] total_wide;
        logic        hit;
        res.idx = idx;
        res.err = 1'b0;
        if (k == KIND_WRITE)
        begin
            if (idx < POP_SIZE)
                wheel[idx] = fit;
            return res;
        end
        total = '0;
        for (int i = 0; i < POP_SIZE; i++)
            total += wheel[i];
        // total under one fitness unit: flagged, no pick
        if (total < ONE_UNIT)
        begin
            res.idx = '0;
            res.err = 1'b1;
            return res;
        end
        r_wide     = r;
        total_wide = total;
        spin       = r_wide * total_wide;
        // first member whose scaled cumulative fitness passes r * total
        res.idx = IDX_W'(POP_SIZE - 1);
        running = '0;
        hit     = 1'b0;
        for (int i = 0; i < POP_SIZE; i++)
        begin
            if (!hit)
            begin
                running += wheel[i];
                scaled = {running, 16'b0};
                if (spin < scaled)
                begin
                    res.idx = IDX_W'(i);
                    hit     = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Random fitness; lean values keep the wheel total near one unit
    function automatic logic [FIT_W-1:0] roll_fitness(input logic lean);
        int roll;
        roll = $urandom_range(0, 9);
        if (lean)
        begin
            if (roll < 4)
                return '0;
            else if (roll < 9)
                return FIT_W'($urandom_range(0, 'h3FFF));
            else
                return FIT_W'($urandom_range(0, 'h3FFFF));
        end
        if (roll < 2)
            return '0;
        else if (roll == 2)
            return '1;
        else if (roll < 5)
            return FIT_W'($urandom_range(0, 'hFFFF));
        else if (roll < 7)
            return FIT_W'($urandom_range(0, 'hFFFFF));
        return FIT_W'($urandom);
    endfunction

    function automatic logic [RAND_IN_W-1:0] roll_fraction();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return '1;
        return RAND_IN_W'($urandom);
    endfunction

    // Present one transaction from a falling edge, hold it until accepted
    task automatic offer(input logic k, input logic [IDX_W-1:0] idx,
                         input logic [FIT_W-1:0] fit, input logic [RAND_IN_W-1:0] r,
                         input logic known, input logic [IDX_W-1:0] t_idx,
                         input logic t_err);
        pick_t want;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        kind            <= k;
        member_index    <= idx;
        fitness_value   <= fit;
        random_fraction <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = spin_wheel(k, idx, fit, r);
        if (known)
        begin
            want.idx = t_idx;
            want.err = t_err;
        end
        pending_picks.push_back(want);
        @(negedge clk);
    endtask

    // Sender pause: hold off until every expected result has come
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_picks.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver stalls
    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_picks.size() == 0)
            begin
                $display("%0t: unexpected result, selected_index %0d error %0b",
                         $time, selected_index, error);
                fail_count++;
            end
            else
            begin
                due = pending_picks.pop_front();
                if (selected_index !== due.idx)
                begin
                    $display("%0t: selected_index mismatch, expected %0d actual %0d",
                             $time, due.idx, selected_index);
                    fail_count++;
                end
                if (error !== due.err)
                begin
                    $display("%0t: error mismatch, expected %0b actual %0b",
                             $time, due.err, error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        probe_row_t       row;
        logic             is_select;
        logic             lean;
        logic [FIT_W-1:0] fit;
        foreach (wheel[i])
            wheel[i] = '0;

        // kind, index, fitness, fraction, known, expected index, expected error
        probes = '{
            // empty wheel after reset, ignored fields set on the second
            '{KIND_SELECT, 7'd0,   32'h0000_0000, 16'h0000, 1'b1, 7'd0,   1'b1},
            '{KIND_SELECT, 7'd127, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 7'd0,   1'b1},
            // total just under one unit
            '{KIND_WRITE,  7'd127, 32'h0000_FFFF, 16'h0000, 1'b1, 7'd127, 1'b0},
            '{KIND_SELECT, 7'd0,   32'h0000_0000, 16'h0000, 1'b1, 7'd0,   1'b1},
            // total exactly one unit: zero entries are never picked
            '{KIND_WRITE,  7'd5,   32'h0000_0001, 16'h0000, 1'b1, 7'd5,   1'b0},
            '{KIND_SELECT, 7'd0,   32'h0000_0000, 16'h0000, 1'b1, 7'd5,   1'b0},
            '{KIND_SELECT, 7'd0,   32'h0000_0000, 16'hFFFF, 1'b1, 7'd127, 1'b0},
            // full-scale entry at the bottom
            '{KIND_WRITE,  7'd0,   32'hFFFF_FFFF, 16'h0000, 1'b1, 7'd0,   1'b0},
            '{KIND_SELECT, 7'd0,   32'h0000_0000, 16'h0000, 1'b1, 7'd0,   1'b0},
            '{KIND_SELECT, 7'd0,   32'h0000_0000, 16'hFFFF, 1'b0, 7'd0,   1'b0},
            '{KIND_WRITE,  7'd64,  32'h8000_0000, 16'h0000, 1'b1, 7'd64,  1'b0},
            '{KIND_SELECT, 7'd0,   32'h0000_0000, 16'h8000, 1'b0, 7'd0,   1'b0},
            '{KIND_WRITE,  7'd127, 32'hFFFF_FFFF, 16'h0000, 1'b1, 7'd127, 1'b0},
            '{KIND_WRITE,  7'h55,  32'hAAAA_AAAA, 16'h0000, 1'b1, 7'h55,  1'b0},
            '{KIND_WRITE,  7'h2A,  32'h5555_5555, 16'h0000, 1'b1, 7'h2A,  1'b0},
            '{KIND_SELECT, 7'h55,  32'h0000_0000, 16'hFFFF, 1'b0, 7'd0,   1'b0},
            '{KIND_SELECT, 7'd0,   32'h0000_0000, 16'h5555, 1'b0, 7'd0,   1'b0},
            '{KIND_SELECT, 7'h2A,  32'h0000_0000, 16'hAAAA, 1'b0, 7'd0,   1'b0},
            // clear back down to a single raw count
            '{KIND_WRITE,  7'd0,   32'h0000_0000, 16'h0000, 1'b1, 7'd0,   1'b0},
            '{KIND_WRITE,  7'd64,  32'h0000_0000, 16'h0000, 1'b1, 7'd64,  1'b0},
            '{KIND_WRITE,  7'd127, 32'h0000_0000, 16'h0000, 1'b1, 7'd127, 1'b0},
            '{KIND_WRITE,  7'h55,  32'h0000_0000, 16'h0000, 1'b1, 7'h55,  1'b0},
            '{KIND_WRITE,  7'h2A,  32'h0000_0000, 16'h0000, 1'b1, 7'h2A,  1'b0},
            '{KIND_SELECT, 7'd0,   32'h0000_0000, 16'h1234, 1'b1, 7'd0,   1'b1},
            '{KIND_WRITE,  7'd5,   32'h0000_0000, 16'h0000, 1'b1, 7'd5,   1'b0}
        };

        // hold reset, then release it on a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int p = 0; p < NPROBE; p++)
        begin
            row = probes[p];
            offer(row.k, row.idx, row.fit, row.r, row.known, row.t_idx, row.t_err);
        end
        drain();

        // random part: mixed traffic, a rewrite of the whole wheel with mostly zero entries, then a lean wheel
        for (int n = 0; n < NRANDOM; n++)
        begin
            calm = (n >= 200 && n < 350);
            lean = (n >= 578 && n < 750);
            if (n == 450)
                drain();
            if (n >= 450 && n < 578)
            begin
                fit = ($urandom_range(0, 9) == 0) ? roll_fitness(1'b1) : '0;
                offer(KIND_WRITE, IDX_W'(n - 450), fit, RAND_IN_W'($urandom),
                      1'b0, '0, 1'b0);
            end
            else
            begin
                is_select = ($urandom_range(0, 99) < 35);
                offer(is_select ? KIND_SELECT : KIND_WRITE, IDX_W'($urandom),
                      roll_fitness(lean), roll_fraction(), 1'b0, '0, 1'b0);
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // wait out every expected result, then let the design settle
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending_picks.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
